/* hw/rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Depends on nothing; every other file of the block depends on it.
package tcw_pkg;

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int OFFSET_W = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_PUT_CHAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEWLINE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_CELL = 3'd4;

    // register index = paddr[2]
    localparam logic REG_TEXT_ATTR  = 1'b0;
    localparam logic REG_BLANK_ATTR = 1'b1;

    localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h07;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
    } cell_t;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attr;
        logic [ATTR_W-1:0] blank_attr;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    localparam cell_t RESET_BLANK = '{attr: ATTR_RESET, ch: BLANK_CHAR};

endpackage

/* hw/rtl/tcw_if.sv */
// Valid/ready channel interfaces for console commands and results.
// Depends on tcw_pkg for field widths.
interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CMD_W-1:0]    command;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, command, char_code, cell_index, input ready);
    modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcw_res_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::OFFSET_W-1:0] cursor_offset;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::ATTR_W-1:0]   cell_attribute;

    modport source (output valid, cursor_offset, cell_char, cell_attribute, input ready);
    modport sink   (input valid, cursor_offset, cell_char, cell_attribute, output ready);
endinterface

/* hw/rtl/text_console_writer_unit.sv */
// Text console writer: a COLUMNS x ROWS screen store held in one synchronous RAM, a cursor,
// a command sequencer and two APB attribute registers. Depends on tcw_pkg, tcw_if,
// tcw_cfg, tcw_screen_mem and tcw_ctrl. One command is worked at a time and its word is
// held in an output register, so the next command is taken while a result waits. Put char,
// newline, backspace, read cell and unused codes go from the execute state to the result
// state and back to idle. Clear walks every cell through the single write port. Put char
// on the pending row scrolls the store, one cell read and written back per cycle, then
// blanks the last row and writes the character at its start. After reset a clearing
// pass fills the store with blanks; no command is taken during it, but configuration
// writes are.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    tcw_cmd_if.sink                       cmd,
    tcw_res_if.source                     res
);
    import tcw_pkg::*;

    localparam int TOTAL = COLUMNS * ROWS;
    localparam int AW    = $clog2(TOTAL);

    cfg_t          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    cell_t         mem_rdata;

    tcw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_screen_mem #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

/* hw/rtl/tcw_cfg.sv */
// APB-style configuration registers: text and blank attributes.
// Depends on tcw_pkg.
module tcw_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tcw_pkg::cfg_t                 cfg
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] text_attr_reg;
    logic [ATTR_W-1:0] blank_attr_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= ATTR_RESET;
            blank_attr_reg <= ATTR_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_TEXT_ATTR)
                text_attr_reg <= pwdata[ATTR_W-1:0];
            else
                blank_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_TEXT_ATTR)
            prdata[ATTR_W-1:0] = text_attr_reg;
        else
            prdata[ATTR_W-1:0] = blank_attr_reg;
    end

    assign cfg = '{text_attr: text_attr_reg, blank_attr: blank_attr_reg};

endmodule

/* hw/rtl/tcw_screen_mem.sv */
// Screen store: one write port and one registered read port.
// Depends on tcw_pkg for the cell type.
module tcw_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  tcw_pkg::cell_t    wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output tcw_pkg::cell_t    rdata
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tcw_ctrl.sv */
// Command sequencer: cursor, store sweeps (init, clear, scroll) and result register.
// Depends on tcw_pkg and tcw_if; drives the ports of tcw_screen_mem.
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::cfg_t     cfg,
    tcw_cmd_if.sink           cmd,
    tcw_res_if.source         res,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output tcw_pkg::cell_t    mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  tcw_pkg::cell_t    mem_rdata
);
    import tcw_pkg::*;

    localparam int TOTAL = COLUMNS * ROWS;
    localparam int IW    = $clog2(TOTAL + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int XW    = (IW > INDEX_W) ? IW : INDEX_W;

    localparam logic [IW-1:0] CUR_TOTAL  = IW'(TOTAL);
    localparam logic [IW-1:0] CUR_COLS   = IW'(COLUMNS);
    localparam logic [IW-1:0] CUR_LASTROW = IW'(TOTAL - COLUMNS);
    localparam logic [AW-1:0] A_LAST     = AW'(TOTAL - 1);
    localparam logic [AW-1:0] A_COLS     = AW'(COLUMNS);
    localparam logic [AW-1:0] A_LASTROW  = AW'(TOTAL - COLUMNS);
    localparam logic [CW-1:0] COL_MAX    = CW'(COLUMNS - 1);
    localparam logic [XW-1:0] X_TOTAL    = XW'(TOTAL);

    state_t               state_reg, state_next;
    logic [IW-1:0]        cursor_reg, cursor_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [AW-1:0]        sweep_reg, sweep_next;
    logic                 pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]        pipe_addr_reg, pipe_addr_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic                 rd_hit_reg, rd_hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0]  out_cursor_reg, out_cursor_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic [ATTR_W-1:0]    out_attr_reg, out_attr_next;

    logic  accept;
    logic  sweep_last;
    logic  pending;
    logic  idx_ok;
    logic  out_free;
    cell_t blank_cell;

    assign accept     = cmd.valid & cmd.ready;
    assign sweep_last = (sweep_reg == A_LAST);
    assign pending    = (cursor_reg == CUR_TOTAL);
    assign idx_ok     = (XW'(idx_reg) < X_TOTAL);
    assign out_free   = ~out_valid_reg | res.ready;
    assign blank_cell = '{attr: cfg.blank_attr, ch: BLANK_CHAR};

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign res.valid          = out_valid_reg;
    assign res.cursor_offset  = out_cursor_reg;
    assign res.cell_char      = out_char_reg;
    assign res.cell_attribute = out_attr_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (sweep_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                    state_next = ST_EXEC;
            ST_EXEC:
                case (cmd_reg)
                    CMD_PUT_CHAR: state_next = pending ? ST_SCROLL : ST_RESP;
                    CMD_CLEAR:    state_next = ST_CLEAR;
                    default:      state_next = ST_RESP;
                endcase
            ST_SCROLL:
                if (sweep_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_BLANK;
            ST_BLANK:
                if (sweep_last)
                    state_next = ST_EXEC;
            ST_CLEAR:
                if (sweep_last)
                    state_next = ST_RESP;
            ST_RESP:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        sweep_next      = sweep_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_addr_next  = pipe_addr_reg;
        cmd_next        = cmd_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        rd_hit_next     = rd_hit_reg;
        out_valid_next  = out_valid_reg & ~res.ready;
        out_cursor_next = out_cursor_reg;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg;
        mem_wdata       = blank_cell;
        mem_re          = 1'b0;
        mem_raddr       = sweep_reg;

        case (state_reg)
            ST_INIT:
            begin
                // reset content is fixed, whatever the register holds by now
                mem_we     = 1'b1;
                mem_wdata  = RESET_BLANK;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
                if (accept)
                begin
                    cmd_next  = cmd.command;
                    char_next = cmd.char_code;
                    idx_next  = cmd.cell_index;
                end
            ST_EXEC:
            begin
                rd_hit_next = 1'b0;
                case (cmd_reg)
                    CMD_PUT_CHAR:
                        if (pending)
                        begin
                            sweep_next      = A_COLS;
                            pipe_valid_next = 1'b0;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = cursor_reg[AW-1:0];
                            mem_wdata   = '{attr: cfg.text_attr, ch: char_reg};
                            cursor_next = cursor_reg + 1'b1;
                            col_next    = (col_reg == COL_MAX) ? '0 : col_reg + 1'b1;
                        end
                    CMD_NEWLINE:
                    begin
                        if (!pending)
                            cursor_next = cursor_reg - IW'(col_reg) + CUR_COLS;
                        col_next = '0;
                    end
                    CMD_BACKSPACE:
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = (col_reg == '0) ? COL_MAX : col_reg - 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = AW'(cursor_reg - 1'b1);
                        end
                    CMD_CLEAR:
                        sweep_next = '0;
                    CMD_READ_CELL:
                    begin
                        rd_hit_next = idx_ok;
                        mem_re      = idx_ok;
                        mem_raddr   = AW'(idx_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCROLL:
            begin
                // read cell i, write it one row up on the next cycle
                mem_re          = 1'b1;
                pipe_valid_next = 1'b1;
                pipe_addr_next  = sweep_reg - A_COLS;
                mem_we          = pipe_valid_reg;
                mem_waddr       = pipe_addr_reg;
                mem_wdata       = mem_rdata;
                sweep_next      = sweep_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pipe_addr_reg;
                mem_wdata  = mem_rdata;
                sweep_next = A_LASTROW;
            end
            ST_BLANK:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    cursor_next = CUR_LASTROW;
                    col_next    = '0;
                end
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    cursor_next = '0;
                    col_next    = '0;
                end
            end
            ST_RESP:
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cursor_next = OFFSET_W'(cursor_reg);
                    out_char_next   = rd_hit_reg ? mem_rdata.ch : '0;
                    out_attr_next   = rd_hit_reg ? mem_rdata.attr : '0;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cursor_reg     <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg  <= pipe_addr_next;
        cmd_reg        <= cmd_next;
        char_reg       <= char_next;
        idx_reg        <= idx_next;
        rd_hit_reg     <= rd_hit_next;
        out_cursor_reg <= out_cursor_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
    end

endmodule

/* hw/rtl/tcw_checker.sv */
// Port-level checks for text_console_writer_unit, attached by bind.
// Depends on tcw_pkg for field widths.
module tcw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [tcw_pkg::OFFSET_W-1:0]  res_cursor_offset,
    input logic [tcw_pkg::CHAR_W-1:0]    res_cell_char,
    input logic [tcw_pkg::ATTR_W-1:0]    res_cell_attribute
);
    // a stalled result word stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_cursor_offset) && $stable(res_cell_char)
            && $stable(res_cell_attribute))
        else $error("result word changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // clearing pass runs right after reset
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !cmd_ready)
        else $error("command port open during clearing pass");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_cursor_offset  (res.cursor_offset),
    .res_cell_char      (res.cell_char),
    .res_cell_attribute (res.cell_attribute)
);
